// File: rtl/u8d_pkg.sv
// Package for the UTF-8 byte stream decoder.
// Holds the decoder state and result types, byte-class masks and register indexes.
// No dependencies.
package u8d_pkg;

    // Configuration register indexes
    localparam logic CFG_ASCII_MODE = 1'b0;
    localparam logic CFG_STRIP_BOM  = 1'b1;

    // Lead and continuation byte class masks
    localparam logic [7:0] MASK_2B   = 8'hE0;
    localparam logic [7:0] MATCH_2B  = 8'hC0;
    localparam logic [7:0] MASK_3B   = 8'hF0;
    localparam logic [7:0] MATCH_3B  = 8'hE0;
    localparam logic [7:0] MASK_4B   = 8'hF8;
    localparam logic [7:0] MATCH_4B  = 8'hF0;
    localparam logic [7:0] MASK_5B   = 8'hFC;
    localparam logic [7:0] MATCH_5B  = 8'hF8;
    localparam logic [7:0] MASK_6B   = 8'hFE;
    localparam logic [7:0] MATCH_6B  = 8'hFC;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] MATCH_CONT = 8'h80;
    localparam logic [7:0] CONT_BITS = 8'h3F;

    // Forbidden and special code points
    localparam logic [30:0] SURR_LO = 31'h0000D800;
    localparam logic [30:0] SURR_HI = 31'h0000DFFF;
    localparam logic [30:0] NONCHAR_FFFE = 31'h0000FFFE;
    localparam logic [30:0] NONCHAR_FFFF = 31'h0000FFFF;
    localparam logic [30:0] BOM = 31'h0000FEFF;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [2:0]  bytes_left;
        logic [2:0]  total_len;
        logic [30:0] acc;
        logic        at_start;
    } t_dec_state;

    // One result of a decode step
    typedef struct packed {
        logic        valid;
        logic [30:0] code_point;
        logic        invalid;
    } t_dec_result;

    // Smallest legal value for a sequence of the given length
    function automatic logic [30:0] min_value(input logic [2:0] len);
        logic [30:0] v;
        begin
            case (len)
                3'd2:    v = 31'h00000080;
                3'd3:    v = 31'h00000800;
                3'd4:    v = 31'h00010000;
                3'd5:    v = 31'h00200000;
                3'd6:    v = 31'h04000000;
                default: v = 31'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/u8d_step.sv
// Combinational decode step: one byte plus the current state gives the next
// state and at most one result. Depends on u8d_pkg.
module u8d_step (
    input  logic                [7:0] i_byte,
    input  logic                      i_end,
    input  logic                      i_ascii_mode,
    input  logic                      i_strip_bom,
    input  u8d_pkg::t_dec_state       i_state,
    output u8d_pkg::t_dec_state       o_state,
    output u8d_pkg::t_dec_result      o_result
);

    logic [30:0] acc_shift;
    logic [2:0]  left_dec;
    logic [30:0] fin_cp;
    logic [2:0]  fin_len;
    logic        fin_bad;
    logic        fin_bom;
    logic        is_cont;

    // Continuation byte shifted into the accumulator
    assign acc_shift = {i_state.acc[24:0], i_byte[5:0]};
    assign left_dec  = i_state.bytes_left - 3'd1;
    assign is_cont   = (i_byte & u8d_pkg::MASK_CONT) == u8d_pkg::MATCH_CONT;

    // Character completion checks: single byte when idle, else the accumulator
    assign fin_cp  = (i_state.bytes_left == 3'd0) ? {23'd0, i_byte} : acc_shift;
    assign fin_len = (i_state.bytes_left == 3'd0) ? 3'd1 : i_state.total_len;
    assign fin_bad = (fin_len >= 3'd2 && fin_cp < u8d_pkg::min_value(fin_len))
                   || (fin_cp >= u8d_pkg::SURR_LO && fin_cp <= u8d_pkg::SURR_HI)
                   || fin_cp == u8d_pkg::NONCHAR_FFFE
                   || fin_cp == u8d_pkg::NONCHAR_FFFF;
    assign fin_bom = fin_cp == u8d_pkg::BOM && i_state.at_start && i_strip_bom;

    // Next state and result
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_end) begin
            o_result.valid   = (i_state.bytes_left != 3'd0) && !i_ascii_mode;
            o_result.invalid = 1'b1;
            o_state          = '0;
            o_state.at_start = 1'b1;
        end else if (i_ascii_mode) begin
            o_state             = '0;
            o_result.valid      = 1'b1;
            o_result.code_point = {23'd0, i_byte};
        end else if (i_state.bytes_left == 3'd0 && i_byte[7]) begin
            // Lead byte opens a sequence, or is illegal
            o_state.at_start = i_state.at_start;
            if ((i_byte & u8d_pkg::MASK_2B) == u8d_pkg::MATCH_2B) begin
                o_state.total_len = 3'd2;
                o_state.acc       = {26'd0, i_byte[4:0]};
            end else if ((i_byte & u8d_pkg::MASK_3B) == u8d_pkg::MATCH_3B) begin
                o_state.total_len = 3'd3;
                o_state.acc       = {27'd0, i_byte[3:0]};
            end else if ((i_byte & u8d_pkg::MASK_4B) == u8d_pkg::MATCH_4B) begin
                o_state.total_len = 3'd4;
                o_state.acc       = {28'd0, i_byte[2:0]};
            end else if ((i_byte & u8d_pkg::MASK_5B) == u8d_pkg::MATCH_5B) begin
                o_state.total_len = 3'd5;
                o_state.acc       = {29'd0, i_byte[1:0]};
            end else if ((i_byte & u8d_pkg::MASK_6B) == u8d_pkg::MATCH_6B) begin
                o_state.total_len = 3'd6;
                o_state.acc       = {30'd0, i_byte[0]};
            end else begin
                o_state.total_len = 3'd0;
                o_state.acc       = '0;
                o_result.valid    = 1'b1;
                o_result.invalid  = 1'b1;
                o_state.at_start  = 1'b0;
            end
            o_state.bytes_left = (o_state.total_len == 3'd0) ? 3'd0 : o_state.total_len - 3'd1;
        end else if (i_state.bytes_left != 3'd0 && !is_cont) begin
            // Broken sequence
            o_state          = '0;
            o_result.valid   = 1'b1;
            o_result.invalid = 1'b1;
        end else if (i_state.bytes_left != 3'd0 && left_dec != 3'd0) begin
            o_state.bytes_left = left_dec;
            o_state.acc        = acc_shift;
        end else begin
            // Character complete: ASCII byte or last continuation byte
            o_state          = '0;
            o_state.at_start = 1'b0;
            if (fin_bad) begin
                o_result.valid   = 1'b1;
                o_result.invalid = 1'b1;
            end else if (!fin_bom) begin
                o_result.valid      = 1'b1;
                o_result.code_point = fin_cp;
            end
        end
    end

endmodule

// File: rtl/utf8_byte_stream_decoder.sv
// Top level of the UTF-8 byte stream decoder: input register, decode step,
// result register and configuration registers. Depends on u8d_pkg, u8d_step.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_in_valid, o_in_ready, i_data_byte,      | in
//          | i_stream_end                              |
//  result  | o_out_valid, i_out_ready, o_code_point,   | out
//          | o_invalid                                 |
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//
// One byte per cycle sustained while results are not stalled; a byte is held in
// the input register and decoded into the result register when it advances, and
// its result is offered from there. Reset is synchronous, active low; it
// clears both registers' valid flags and the decoder state and returns the
// configuration to its defaults.
// A stalled result holds the pipe; the input register still takes a new byte
// whenever its contents move into the result register on the same edge.
module utf8_byte_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_code_point,
    output logic        o_invalid
);

    logic                   r_ascii_mode;
    logic                   r_strip_bom;
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_end;
    u8d_pkg::t_dec_state    r_state;
    u8d_pkg::t_dec_state    n_state;
    u8d_pkg::t_dec_result   n_result;
    logic                   r_out_valid;
    logic [30:0]            r_code_point;
    logic                   r_invalid;
    logic                   advance;

    // Byte moves out of the input register when the result register is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii_mode <= 1'b0;
            r_strip_bom  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                u8d_pkg::CFG_ASCII_MODE: r_ascii_mode <= i_cfg_data;
                u8d_pkg::CFG_STRIP_BOM:  r_strip_bom  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    u8d_step u_step (
        .i_byte       (r_in_byte),
        .i_end        (r_in_end),
        .i_ascii_mode (r_ascii_mode),
        .i_strip_bom  (r_strip_bom),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{bytes_left: 3'd0, total_len: 3'd0, acc: 31'd0, at_start: 1'b1};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.valid) begin
            r_code_point <= n_result.code_point;
            r_invalid    <= n_result.invalid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_invalid    = r_invalid;

    // An invalid result never carries a code point
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_invalid |-> r_code_point == 31'd0)
        else $error("invalid result with nonzero code point");

    // An open sequence always has a legal length and fewer bytes left than it
    a_open_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_left != 3'd0 |->
            r_state.bytes_left < r_state.total_len && r_state.total_len >= 3'd2
            && r_state.total_len <= 3'd6)
        else $error("inconsistent sequence length state");

    // End of stream always leaves the decoder idle and re-armed
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_end |=> r_state.bytes_left == 3'd0 && r_state.at_start)
        else $error("decoder not idle after end of stream");

    // Pass-through mode never leaves a sequence open
    a_ascii_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_ascii_mode |=> r_state.bytes_left == 3'd0)
        else $error("sequence open in pass-through mode");

endmodule
